>>> hdl/saa_pkg.sv
// ----------------------------------------------------------------------------
// saa_pkg
// Shared types and constants of the skyline atlas allocator: request codes,
// field widths, controller states and the command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package saa_pkg;

	// request codes
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// fixed field widths
	localparam int RECT_W   = 11;
	localparam int CORNER_W = 10;

	// controller states
	typedef enum logic [3:0] {
		ST_WIPE,
		ST_IDLE,
		ST_DISPATCH,
		ST_CLEAR,
		ST_PRE,
		ST_SUF,
		ST_SUF_END,
		ST_DECIDE,
		ST_UPD,
		ST_DONE
	} saa_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture request fields, reset scan state
		logic cnt_zero;  // column counter to zero
		logic cnt_top;   // column counter to last column
		logic cnt_inc;
		logic cnt_dec;
		logic clear_wr;  // write zero height at counter
		logic pre_rd;    // prefix pass read at counter
		logic suf_rd;    // suffix pass read at counter
		logic upd_wr;    // raise column at pick + counter
		logic out_load;  // load result register
	} saa_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_clear;
		logic bad;          // zero size or width not below atlas size
		logic fit;          // a start was found and the rectangle fits
		logic cnt_at_top;
		logic cnt_at_zero;
		logic cnt_at_wlast; // counter equals width minus one
	} saa_sts_t;

endpackage

`default_nettype wire

>>> hdl/saa_ctrl.sv
// ----------------------------------------------------------------------------
// saa_ctrl
// Controller of the skyline atlas allocator. Sequences the wipe after reset,
// the clear sweep, the prefix and suffix scans, the column update and the
// hand-over of the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module saa_ctrl
	import saa_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	output saa_cmd_t      cmd,
	input  wire saa_sts_t sts
);

	saa_state_t state_q;
	saa_state_t state_d;
	logic       out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
		end else begin
			state_q <= state_d;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_WIPE: begin
				if (sts.cnt_at_top) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (sts.is_clear) begin
					state_d = ST_CLEAR;
				end else if (sts.bad) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_PRE;
				end
			end
			ST_CLEAR: begin
				if (sts.cnt_at_top) state_d = ST_DONE;
			end
			ST_PRE: begin
				if (sts.cnt_at_top) state_d = ST_SUF;
			end
			ST_SUF: begin
				if (sts.cnt_at_zero) state_d = ST_SUF_END;
			end
			ST_SUF_END: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = sts.fit ? ST_UPD : ST_DONE;
			end
			ST_UPD: begin
				if (sts.cnt_at_wlast) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_WIPE, ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				cmd.cnt_zero = sts.cnt_at_top;
				cmd.cnt_inc  = !sts.cnt_at_top;
			end
			ST_IDLE: begin
				cmd.load     = in_valid;
				cmd.cnt_zero = in_valid;
			end
			ST_PRE: begin
				cmd.pre_rd  = 1'b1;
				cmd.cnt_inc = !sts.cnt_at_top;
			end
			ST_SUF: begin
				cmd.suf_rd  = 1'b1;
				cmd.cnt_dec = !sts.cnt_at_zero;
			end
			ST_DECIDE: begin
				cmd.cnt_zero = 1'b1;
			end
			ST_UPD: begin
				cmd.upd_wr  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = !out_valid_q || !out_stall;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/saa_datapath.sv
// ----------------------------------------------------------------------------
// saa_datapath
// Datapath of the skyline atlas allocator: column height memory, block prefix
// maximum memory, column counter, the sliding window maximum built from block
// prefix and suffix maxima, the best start tracker and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module saa_datapath
	import saa_pkg::*;
#(
	parameter int ATLAS_SIZE = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire saa_cmd_t            cmd,
	output saa_sts_t                 sts,
	input  wire logic                req_type,
	input  wire logic [RECT_W-1:0]   rect_width,
	input  wire logic [RECT_W-1:0]   rect_height,
	output logic                     placed,
	output logic [CORNER_W-1:0]      corner_x,
	output logic [CORNER_W-1:0]      corner_y
);

	localparam int AW = $clog2(ATLAS_SIZE);
	localparam int HW = $clog2(ATLAS_SIZE + 1);
	localparam int WW = ((HW > RECT_W) ? HW : RECT_W) + 1;

	// request
	logic              req_type_q;
	logic [RECT_W-1:0] w_q;
	logic [RECT_W-1:0] h_q;

	// column counter
	logic [AW-1:0] idx_q;

	// memories
	logic [HW-1:0] col_mem [ATLAS_SIZE];
	logic [HW-1:0] pfx_mem [ATLAS_SIZE];

	// read stage
	logic          pre_v_s1;
	logic          suf_v_s1;
	logic [AW-1:0] idx_s1;
	logic [HW-1:0] col_h_s1;
	logic [HW-1:0] pfx_h_s1;

	// scan state
	logic [AW-1:0] pre_off_q;
	logic [HW-1:0] pm_q;
	logic [AW-1:0] last_off_q;
	logic [AW-1:0] sfx_off_q;
	logic [HW-1:0] sm_q;
	logic          bend_q;
	logic [HW-1:0] best_q;
	logic [AW-1:0] pick_q;
	logic          found_q;

	// result register
	logic                placed_q;
	logic [CORNER_W-1:0] corner_x_q;
	logic [CORNER_W-1:0] corner_y_q;

	// derived values
	logic [WW-1:0] w_ext;
	logic [WW-1:0] h_ext;
	logic [WW-1:0] n_ext;
	logic [WW-1:0] wm1_ext;
	logic [AW-1:0] wlast;
	logic [WW-1:0] sum_ext;
	logic [HW-1:0] new_h;
	logic          req_clr;
	logic          fit;
	logic [AW-1:0] sfx_addr;
	logic [AW-1:0] upd_addr;
	logic          col_we;
	logic [AW-1:0] col_waddr;
	logic [HW-1:0] col_wdata;
	logic [HW-1:0] pm;
	logic          sfx_first;
	logic [AW-1:0] sfx_off;
	logic          sfx_bend;
	logic [HW-1:0] sm;
	logic [HW-1:0] top;
	logic          eligible;
	logic          take;

	assign w_ext    = WW'(w_q);
	assign h_ext    = WW'(h_q);
	assign n_ext    = WW'(ATLAS_SIZE);
	assign wm1_ext  = w_ext - WW'(1);
	assign wlast    = wm1_ext[AW-1:0];
	assign sum_ext  = WW'(best_q) + h_ext;
	assign new_h    = sum_ext[HW-1:0];
	assign req_clr  = (req_type_q == REQ_CLEAR);
	assign fit      = found_q && (sum_ext <= n_ext);
	assign sfx_addr = AW'(WW'(idx_q) + wm1_ext);
	assign upd_addr = pick_q + idx_q;

	// status
	always_comb begin
		sts.is_clear     = req_clr;
		sts.bad          = (w_q == '0) || (h_q == '0) || (w_ext >= n_ext);
		sts.fit          = fit;
		sts.cnt_at_top   = (idx_q == AW'(ATLAS_SIZE - 1));
		sts.cnt_at_zero  = (idx_q == '0);
		sts.cnt_at_wlast = (idx_q == wlast);
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			w_q        <= rect_width;
			h_q        <= rect_height;
		end
	end

	// column counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.cnt_zero) begin
			idx_q <= '0;
		end else if (cmd.cnt_top) begin
			idx_q <= AW'(ATLAS_SIZE - 1);
		end else if (cmd.cnt_inc) begin
			idx_q <= idx_q + AW'(1);
		end else if (cmd.cnt_dec) begin
			idx_q <= idx_q - AW'(1);
		end
	end

	// column memory write select
	always_comb begin
		col_we    = cmd.clear_wr || cmd.upd_wr;
		col_waddr = cmd.upd_wr ? upd_addr : idx_q;
		col_wdata = cmd.upd_wr ? new_h : '0;
	end

	// column height memory
	always_ff @(posedge clk) begin
		if (col_we) col_mem[col_waddr] <= col_wdata;
		if (cmd.pre_rd || cmd.suf_rd) col_h_s1 <= col_mem[idx_q];
	end

	// block prefix maximum memory
	always_ff @(posedge clk) begin
		if (pre_v_s1) pfx_mem[idx_s1] <= pm;
		if (cmd.suf_rd) pfx_h_s1 <= pfx_mem[sfx_addr];
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_v_s1 <= 1'b0;
			suf_v_s1 <= 1'b0;
		end else begin
			pre_v_s1 <= cmd.pre_rd;
			suf_v_s1 <= cmd.suf_rd;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	// prefix maximum within blocks of width columns
	assign pm = (pre_off_q == '0) ? col_h_s1 : ((col_h_s1 > pm_q) ? col_h_s1 : pm_q);

	// suffix maximum within blocks, walked from the right
	always_comb begin
		sfx_first = (idx_s1 == AW'(ATLAS_SIZE - 1));
		sfx_off   = sfx_first ? last_off_q : sfx_off_q;
		sfx_bend  = sfx_first || bend_q;
		sm        = sfx_bend ? col_h_s1 : ((col_h_s1 > sm_q) ? col_h_s1 : sm_q);
		top       = (sm > pfx_h_s1) ? sm : pfx_h_s1;
		eligible  = (WW'(idx_s1) + w_ext) < n_ext;
		take      = suf_v_s1 && eligible && (top < HW'(ATLAS_SIZE)) && (top <= best_q);
	end

	// scan state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pre_off_q <= '0;
			best_q    <= HW'(ATLAS_SIZE);
			pick_q    <= '0;
			found_q   <= 1'b0;
		end else begin
			if (pre_v_s1) begin
				pm_q      <= pm;
				pre_off_q <= (pre_off_q == wlast) ? '0 : pre_off_q + AW'(1);
				if (idx_s1 == AW'(ATLAS_SIZE - 1)) last_off_q <= pre_off_q;
			end
			if (suf_v_s1) begin
				sm_q      <= sm;
				sfx_off_q <= (sfx_off == '0) ? wlast : sfx_off - AW'(1);
				bend_q    <= (sfx_off == '0);
			end
			// right to left with non-strict compare keeps the leftmost lowest start
			if (take) begin
				best_q  <= top;
				pick_q  <= idx_s1;
				found_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			placed_q   <= req_clr || fit;
			corner_x_q <= (!req_clr && fit) ? CORNER_W'(pick_q) : '0;
			corner_y_q <= (!req_clr && fit) ? CORNER_W'(best_q) : '0;
		end
	end

	assign placed   = placed_q;
	assign corner_x = corner_x_q;
	assign corner_y = corner_y_q;

endmodule

`default_nettype wire

>>> hdl/skyline_atlas_allocator.sv
// ----------------------------------------------------------------------------
// skyline_atlas_allocator
// Square texture atlas allocator keeping one fill height per column.
//
// Input channel (in_valid / in_stall): req_type, rect_width, rect_height.
// Output channel (out_valid / out_stall): placed, corner_x, corner_y, one
// result transaction per input transaction, in order.
// One request is worked on at a time; in_stall is high while it runs.
// An allocate request runs a prefix pass and a suffix pass over the column
// memory, one column per cycle each, then raises the columns one per cycle.
// A clear request writes zero heights, one column per cycle. A rejected
// request (zero size, width not below ATLAS_SIZE) skips the scans. After
// reset the column memory is swept to zero with in_stall high. A finished
// result sits in the output register while the next request is taken; if
// the receiver stalls, the following result waits inside the block until
// the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module skyline_atlas_allocator
	import saa_pkg::*;
#(
	parameter int ATLAS_SIZE = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                req_type,
	input  wire logic [RECT_W-1:0]   rect_width,
	input  wire logic [RECT_W-1:0]   rect_height,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     placed,
	output logic [CORNER_W-1:0]      corner_x,
	output logic [CORNER_W-1:0]      corner_y
);

	saa_cmd_t cmd;
	saa_sts_t sts;

	// controller
	saa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath
	saa_datapath #(
		.ATLAS_SIZE (ATLAS_SIZE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.placed      (placed),
		.corner_x    (corner_x),
		.corner_y    (corner_y)
	);

	// a taken transaction closes the input until its result is queued
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepted transaction");

	// a new result only appears while a request is in flight
	a_result_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no request in flight");

	// a failed placement reports a zero corner
	a_fail_zero_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !placed |-> corner_x == '0 && corner_y == '0)
		else $error("failed placement with non-zero corner");

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the skyline atlas allocator. A short table of
// directed requests covers clears, rejected sizes, full atlas, oversize
// heights and the untried last start column, then about 290 random requests
// follow. Every result is checked against the table entry or a column height
// model kept in the bench. Both channels idle and stall at random, and the
// output side holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb;
	import saa_pkg::*;

	localparam int ATLAS       = 1024;
	localparam int RANDOM_REQS = 290;
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLDOFF_LEN = 5000;

	typedef struct packed {
		logic              kind;
		logic [RECT_W-1:0] width;
		logic [RECT_W-1:0] height;
	} alloc_req_t;

	typedef struct packed {
		logic                placed;
		logic [CORNER_W-1:0] corner_x;
		logic [CORNER_W-1:0] corner_y;
	} placement_t;

	typedef struct packed {
		alloc_req_t rq;
		logic       typed;
		placement_t want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                req_type;
	logic [RECT_W-1:0]   rect_width;
	logic [RECT_W-1:0]   rect_height;
	logic                out_valid;
	logic                out_stall;
	logic                placed;
	logic [CORNER_W-1:0] corner_x;
	logic [CORNER_W-1:0] corner_y;

	// column heights as the bench sees them, plus block-wise running maxima
	int skyline [ATLAS];
	int run_pre [ATLAS];
	int run_suf [ATLAS];

	placement_t pending_placements[$];
	plan_row_t  directed_plan[$];
	int         mismatches   = 0;
	int         results_seen = 0;
	int         quiet_cycles = 0;
	bit         gaps_on      = 1'b1;

	skyline_atlas_allocator #(
		.ATLAS_SIZE(ATLAS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.placed     (placed),
		.corner_x   (corner_x),
		.corner_y   (corner_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// place one rectangle on the skyline, or clear it
	function automatic placement_t place_rect(input alloc_req_t rq);
		placement_t res;
		int w;
		int h;
		int k;
		int best;
		int pick;
		int span_top;
		bit found;
		res = '0;
		w = int'(rq.width);
		h = int'(rq.height);
		if (rq.kind == REQ_CLEAR) begin
			for (k = 0; k < ATLAS; k++)
				skyline[k] = 0;
			res.placed = 1'b1;
			return res;
		end
		if (w == 0 || h == 0 || w >= ATLAS)
			return res;
		// maxima within blocks of length w, so any window spans two runs
		for (k = 0; k < ATLAS; k++) begin
			if (k % w == 0 || skyline[k] > run_pre[k-1])
				run_pre[k] = skyline[k];
			else
				run_pre[k] = run_pre[k-1];
		end
		for (k = ATLAS - 1; k >= 0; k--) begin
			if (k == ATLAS - 1 || k % w == w - 1 || skyline[k] > run_suf[k+1])
				run_suf[k] = skyline[k];
			else
				run_suf[k] = run_suf[k+1];
		end
		// leftmost start with the lowest window top; last start is skipped
		best = ATLAS;
		pick = 0;
		found = 1'b0;
		for (k = 0; k < ATLAS - w; k++) begin
			span_top = (run_suf[k] > run_pre[k+w-1]) ? run_suf[k] : run_pre[k+w-1];
			if (span_top < best) begin
				best = span_top;
				pick = k;
				found = 1'b1;
			end
		end
		if (!found || best + h > ATLAS)
			return res;
		for (k = pick; k < pick + w; k++)
			skyline[k] = best + h;
		res.placed = 1'b1;
		res.corner_x = CORNER_W'(pick);
		res.corner_y = CORNER_W'(best);
		return res;
	endfunction

	function automatic alloc_req_t random_request();
		alloc_req_t rq;
		int pick;
		pick = $urandom_range(0, 99);
		rq.kind = REQ_ALLOC;
		rq.width = RECT_W'($urandom_range(1, 32));
		rq.height = RECT_W'($urandom_range(1, 128));
		if (pick < 3) begin
			rq.kind = REQ_CLEAR;
			rq.width = RECT_W'($urandom_range(0, 2047));
			rq.height = RECT_W'($urandom_range(0, 2047));
		end else if (pick < 6) begin
			if ($urandom_range(0, 1))
				rq.width = '0;
			else
				rq.height = '0;
		end else if (pick < 9) begin
			rq.width = RECT_W'($urandom_range(1024, 2047));
		end else if (pick < 12) begin
			rq.width = RECT_W'($urandom_range(1, 600));
			rq.height = RECT_W'($urandom_range(1025, 2047));
		end else if (pick < 50) begin
			// small rectangles, the common case
		end else if (pick < 85) begin
			rq.width = RECT_W'($urandom_range(33, 400));
			rq.height = RECT_W'($urandom_range(1, 256));
		end else begin
			rq.width = RECT_W'($urandom_range(401, 1023));
			rq.height = RECT_W'($urandom_range(1, 1024));
		end
		return rq;
	endfunction

	task automatic plan_row(input logic kind, input int w, input int h, input logic typed,
			input logic ok, input int cx, input int cy);
		plan_row_t row;
		row.rq.kind = kind;
		row.rq.width = RECT_W'(w);
		row.rq.height = RECT_W'(h);
		row.typed = typed;
		row.want.placed = ok;
		row.want.corner_x = CORNER_W'(cx);
		row.want.corner_y = CORNER_W'(cy);
		directed_plan.push_back(row);
	endtask

	// offer one request from a falling edge until accepted
	task automatic send_request(input alloc_req_t rq, output placement_t predicted);
		while (gaps_on && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq.kind;
		rect_width <= rq.width;
		rect_height <= rq.height;
		do
			@(posedge clk);
		while (in_stall);
		predicted = place_rect(rq);
		@(negedge clk);
	endtask

	// request side
	initial begin
		placement_t predicted;
		alloc_req_t rq;
		int n;
		in_valid = 1'b0;
		req_type = REQ_ALLOC;
		rect_width = '0;
		rect_height = '0;
		arst_n = 1'b0;
		for (n = 0; n < ATLAS; n++)
			skyline[n] = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed table: kind, width, height, typed, placed, x, y
		plan_row(REQ_ALLOC, 1, 1, 1, 1, 0, 0);
		plan_row(REQ_ALLOC, 0, 5, 1, 0, 0, 0);
		plan_row(REQ_ALLOC, 5, 0, 1, 0, 0, 0);
		plan_row(REQ_ALLOC, 1024, 1, 1, 0, 0, 0);
		plan_row(REQ_ALLOC, 2047, 2047, 1, 0, 0, 0);
		plan_row(REQ_ALLOC, 1023, 1, 1, 1, 0, 1);
		// the free rightmost column is never tried
		plan_row(REQ_ALLOC, 1, 1, 1, 1, 0, 2);
		plan_row(REQ_CLEAR, 0, 0, 1, 1, 0, 0);
		plan_row(REQ_ALLOC, 1, 1024, 1, 1, 0, 0);
		plan_row(REQ_ALLOC, 1, 1, 1, 1, 1, 0);
		// height larger than the free space
		plan_row(REQ_ALLOC, 2, 2047, 1, 0, 0, 0);
		plan_row(REQ_ALLOC, 3, 700, 0, 0, 0, 0);
		plan_row(REQ_ALLOC, 40, 300, 0, 0, 0, 0);
		plan_row(REQ_CLEAR, 0, 0, 1, 1, 0, 0);
		plan_row(REQ_ALLOC, 1023, 1024, 1, 1, 0, 0);
		// no start below the top of the atlas
		plan_row(REQ_ALLOC, 1, 1, 1, 0, 0, 0);
		plan_row(REQ_CLEAR, 2047, 2047, 1, 1, 0, 0);
		plan_row(REQ_ALLOC, 1023, 1023, 1, 1, 0, 0);
		plan_row(REQ_ALLOC, 1, 1, 1, 1, 0, 1023);
		plan_row(REQ_ALLOC, 1, 2, 1, 0, 0, 0);
		plan_row(REQ_ALLOC, 1022, 1, 0, 0, 0, 0);
		plan_row(REQ_CLEAR, 0, 0, 1, 1, 0, 0);
		plan_row(REQ_ALLOC, 1022, 1, 1, 1, 0, 0);
		plan_row(REQ_ALLOC, 2, 1, 0, 0, 0, 0);

		@(negedge clk);
		foreach (directed_plan[i]) begin
			send_request(directed_plan[i].rq, predicted);
			pending_placements.push_back(directed_plan[i].typed ?
				directed_plan[i].want : predicted);
		end

		// random part, with a stretch free of idling on both sides
		for (n = 0; n < RANDOM_REQS; n++) begin
			gaps_on <= !(n >= 120 && n < 170);
			rq = random_request();
			send_request(rq, predicted);
			pending_placements.push_back(predicted);
		end
		in_valid <= 1'b0;
		gaps_on <= 1'b1;

		while (pending_placements.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// result side stall, with one long hold-off to back the block up
	initial begin
		int holdoff;
		bit held;
		holdoff = 0;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 30) begin
				held = 1'b1;
				holdoff = HOLDOFF_LEN;
			end
			if (holdoff > 0) begin
				out_stall <= 1'b1;
				holdoff--;
			end else begin
				out_stall <= gaps_on && ($urandom_range(0, 99) < 29);
			end
		end
	end

	// compare each result transaction with the oldest pending placement
	always @(posedge clk) begin
		placement_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (pending_placements.size() == 0) begin
				$display("%0t unexpected result: placed %0d x %0d y %0d",
					$time, placed, corner_x, corner_y);
				mismatches <= mismatches + 1;
			end else begin
				want = pending_placements.pop_front();
				if (placed !== want.placed || corner_x !== want.corner_x ||
						corner_y !== want.corner_y) begin
					if (placed !== want.placed)
						$display("%0t placed: expected %0d, actual %0d",
							$time, want.placed, placed);
					if (corner_x !== want.corner_x)
						$display("%0t corner_x: expected %0d, actual %0d",
							$time, want.corner_x, corner_x);
					if (corner_y !== want.corner_y)
						$display("%0t corner_y: expected %0d, actual %0d",
							$time, want.corner_y, corner_y);
					mismatches <= mismatches + 1;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t timeout, %0d results pending", $time, pending_placements.size());
			$display("tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
